>>> rtl/ppv_pkg.sv
// Shared types, constants and a saturating helper function for the point projection block.
package ppv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 32 + FRAC_BITS;        // |p| << FRAC_BITS
    localparam int DCNT_W    = $clog2(NUM_W);
    localparam int PSH_W     = 64 - FRAC_BITS;        // product after the shift
    localparam int ACC_W     = PSH_W + 2;             // three products plus a coefficient
    localparam int MAP_W     = 66;
    localparam int NDC_W     = 48;
    localparam int W_MIN     = ((1 << FRAC_BITS) + 5) / 10;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_TOP    = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    typedef struct packed {
        logic        op;
        logic [3:0]  idx;
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] v2;
    } entry_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
    } view_t;

    function automatic logic signed [31:0] sat32(input logic signed [MAP_W-1:0] v);
        logic signed [MAP_W-1:0] hi;
        logic signed [MAP_W-1:0] lo;
        hi = MAP_W'(32'sh7fffffff);
        lo = MAP_W'(-33'sh80000000);
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

>>> rtl/ppv_if.sv
// Valid/ready channel interfaces for input items and results.
interface ppv_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [3:0]  coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;

    modport source (output valid, opcode, coef_index, coef_value, world_x, world_y, world_z,
                    input ready);
    modport sink   (input valid, opcode, coef_index, coef_value, world_x, world_y, world_z,
                    output ready);
endinterface

interface ppv_out_if;
    logic        valid;
    logic        ready;
    logic        projected_ok;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] screen_depth;

    modport source (output valid, projected_ok, screen_x, screen_y, screen_depth,
                    input ready);
    modport sink   (input valid, projected_ok, screen_x, screen_y, screen_depth,
                    output ready);
endinterface

>>> rtl/point_projection_to_viewport.sv
// Top level of the point projection and viewport mapping block.
//
//  channel   dir  handshake             beat contents
//  in_ch     in   valid/ready           opcode, coef_index, coef_value, world_x/y/z
//  out_ch    out  valid/ready           projected_ok, screen_x, screen_y, screen_depth
//  apb       in   psel/penable/pready   paddr, pwdata, prdata (viewport registers)
//
// A load beat writes one coefficient; a project beat runs the multiply-accumulate
// on the single 32x32 multiplier, a check of w, the three-lane bit-serial divider,
// then normalise and viewport map; a failed projection (w too small) ends after
// the check. rst_n clears the coefficients, viewport and all control.
// Up to five beats wait in the front register and queue while the back stage
// works or while a result waits on out_ch.ready.
module point_projection_to_viewport (
    input  logic        clk,
    input  logic        rst_n,
    ppv_in_if.sink      in_ch,
    ppv_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ppv_pkg::view_t  view;
    ppv_pkg::entry_t f_entry;
    ppv_pkg::entry_t q_head;
    logic            f_push;
    logic            q_full;
    logic            q_avail;
    logic            q_pop;

    ppv_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .view    (view)
    );

    ppv_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .push  (f_push),
        .full  (q_full),
        .entry (f_entry)
    );

    ppv_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_entry (f_entry),
        .full       (q_full),
        .pop        (q_pop),
        .avail      (q_avail),
        .head       (q_head)
    );

    ppv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_avail (q_avail),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .view    (view),
        .out_ch  (out_ch)
    );

endmodule

>>> rtl/ppv_regs.sv
// APB viewport register file.
module ppv_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output ppv_pkg::view_t      view
);

    ppv_pkg::view_t view_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign view   = view_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                ppv_pkg::REG_LEFT:   view_reg.left   <= pwdata[15:0];
                ppv_pkg::REG_TOP:    view_reg.top    <= pwdata[15:0];
                ppv_pkg::REG_WIDTH:  view_reg.width  <= pwdata[15:0];
                ppv_pkg::REG_HEIGHT: view_reg.height <= pwdata[15:0];
                default:             view_reg <= view_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ppv_pkg::REG_LEFT:   prdata = {16'd0, view_reg.left};
            ppv_pkg::REG_TOP:    prdata = {16'd0, view_reg.top};
            ppv_pkg::REG_WIDTH:  prdata = {16'd0, view_reg.width};
            ppv_pkg::REG_HEIGHT: prdata = {16'd0, view_reg.height};
            default:             prdata = '0;
        endcase
    end

endmodule

>>> rtl/ppv_front.sv
// Front stage: accepts input beats and packs them into queue entries by opcode.
module ppv_front (
    input  logic              clk,
    input  logic              rst_n,
    ppv_in_if.sink            in_ch,
    output logic              push,
    input  logic              full,
    output ppv_pkg::entry_t   entry
);

    logic            valid_reg;
    ppv_pkg::entry_t entry_reg;
    ppv_pkg::entry_t entry_next;

    assign in_ch.ready = !valid_reg || !full;
    assign push        = valid_reg;
    assign entry       = entry_reg;

    always_comb
    begin
        entry_next     = '0;
        entry_next.op  = in_ch.opcode;
        entry_next.idx = in_ch.coef_index;
        if (in_ch.opcode == ppv_pkg::OP_LOAD)
        begin
            entry_next.v0 = in_ch.coef_value;
        end
        else
        begin
            entry_next.v0 = in_ch.world_x;
            entry_next.v1 = in_ch.world_y;
            entry_next.v2 = in_ch.world_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ch.valid && in_ch.ready)
            valid_reg <= 1'b1;
        else if (!full)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            entry_reg <= entry_next;
    end

endmodule

>>> rtl/ppv_fifo.sv
// Short queue of entries between the front and back stages.
module ppv_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ppv_pkg::entry_t   push_entry,
    output logic              full,
    input  logic              pop,
    output logic              avail,
    output ppv_pkg::entry_t   head
);

    ppv_pkg::entry_t              mem_reg [ppv_pkg::FIFO_DEPTH];
    logic [ppv_pkg::FIFO_AW-1:0]  wptr_reg;
    logic [ppv_pkg::FIFO_AW-1:0]  rptr_reg;
    logic [ppv_pkg::FIFO_AW:0]    count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign full    = (count_reg == (ppv_pkg::FIFO_AW+1)'(ppv_pkg::FIFO_DEPTH));
    assign avail   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && avail;
    assign head    = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= push_entry;
    end

endmodule

>>> rtl/ppv_back.sv
// Back stage: coefficient store, matrix multiply-accumulate, divide by w, viewport map.
module ppv_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_avail,
    output logic              q_pop,
    input  ppv_pkg::entry_t   q_head,
    input  ppv_pkg::view_t    view,
    ppv_out_if.source         out_ch
);

    localparam int F = ppv_pkg::FRAC_BITS;
    localparam int MW = ppv_pkg::MAP_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_NORM  = 3'd4;
    localparam logic [2:0] ST_MAP1  = 3'd5;
    localparam logic [2:0] ST_MAP2  = 3'd6;

    logic [2:0]                    state_reg;
    logic [3:0]                    cnt_reg;
    logic signed [31:0]            coef_reg [16];
    logic signed [31:0]            pt_reg [3];
    logic signed [31:0]            p_reg [4];
    logic signed [ppv_pkg::ACC_W-1:0] acc_reg;
    logic [ppv_pkg::DCNT_W-1:0]    dcnt_reg;
    logic [32:0]                   rem_reg [3];
    logic [ppv_pkg::NUM_W-1:0]     quo_reg [3];
    logic                          neg_reg [3];
    logic [31:0]                   dvs_reg;
    logic signed [ppv_pkg::NDC_W-1:0] n_reg [3];
    logic signed [MW-1:0]          mx_reg;
    logic signed [MW-1:0]          my_reg;

    logic                          ov_reg;
    logic                          ok_reg;
    logic signed [31:0]            sx_reg;
    logic signed [31:0]            sy_reg;
    logic signed [31:0]            sd_reg;

    // multiply-accumulate path
    logic [1:0]                    col;
    logic [1:0]                    term;
    logic [3:0]                    coef_addr;
    logic signed [31:0]            mac_in;
    logic signed [31:0]            coef_rd;
    logic signed [63:0]            prod;
    logic signed [ppv_pkg::ACC_W-1:0] sum;

    // w check and divider
    logic signed [32:0]            w_ext;
    logic [32:0]                   abs_w;
    logic                          w_small;
    logic [32:0]                   abs_p [3];
    logic [32:0]                   rs [3];
    logic                          ge [3];
    logic signed [63:0]            qs [3];
    logic signed [63:0]            qc [3];

    // viewport map
    logic signed [MW-1:0]          ax;
    logic signed [MW-1:0]          ay;
    logic signed [MW-1:0]          sx;
    logic signed [MW-1:0]          sy;
    logic signed [MW-1:0]          cx;
    logic signed [MW-1:0]          cy;
    logic signed [MW-1:0]          dx;
    logic signed [MW-1:0]          dy;
    logic signed [MW-1:0]          tol;
    logic                          snap;

    assign col  = cnt_reg[3:2];
    assign term = cnt_reg[1:0];

    assign out_ch.valid        = ov_reg;
    assign out_ch.projected_ok = ok_reg;
    assign out_ch.screen_x     = sx_reg;
    assign out_ch.screen_y     = sy_reg;
    assign out_ch.screen_depth = sd_reg;

    assign q_pop = (state_reg == ST_IDLE) && q_avail && !ov_reg;

    always_comb
    begin
        case (term)
            2'd1:    mac_in = pt_reg[0];
            2'd2:    mac_in = pt_reg[1];
            default: mac_in = pt_reg[2];
        endcase
        if (term == 2'd0)
            coef_addr = {2'd3, col};
        else
            coef_addr = {term - 2'd1, col};
        coef_rd = coef_reg[coef_addr];
        prod    = 64'(mac_in) * 64'(coef_rd);
        sum     = acc_reg + ppv_pkg::ACC_W'(prod >>> F);
    end

    always_comb
    begin
        w_ext   = 33'(p_reg[3]);
        abs_w   = w_ext[32] ? 33'(-w_ext) : w_ext;
        w_small = (abs_w < 33'(ppv_pkg::W_MIN));
        for (int i = 0; i < 3; i++)
        begin
            abs_p[i] = p_reg[i][31] ? 33'(-33'(p_reg[i])) : 33'(p_reg[i]);
            rs[i]    = {rem_reg[i][31:0], quo_reg[i][ppv_pkg::NUM_W-1]};
            ge[i]    = (rs[i] >= {1'b0, dvs_reg});
            qs[i]    = neg_reg[i] ? -64'({1'b0, quo_reg[i]}) : 64'({1'b0, quo_reg[i]});
            if (qs[i] > (64'sd1 <<< 46))
                qc[i] = 64'sd1 <<< 46;
            else if (qs[i] < -(64'sd1 <<< 46))
                qc[i] = -(64'sd1 <<< 46);
            else
                qc[i] = qs[i];
        end
    end

    always_comb
    begin
        ax  = (MW'(1) <<< F) + MW'(n_reg[0]);
        ay  = (MW'(1) <<< F) - MW'(n_reg[1]);
        sx  = (MW'($signed({1'b0, view.left})) <<< F) + (mx_reg >>> 1);
        sy  = (MW'($signed({1'b0, view.top})) <<< F) + (my_reg >>> 1);
        cx  = MW'($signed({1'b0, {1'b0, view.left, 1'b0} + 18'(view.width)})) <<< (F - 1);
        cy  = MW'($signed({1'b0, {1'b0, view.top, 1'b0} + 18'(view.height)})) <<< (F - 1);
        dx  = sx - cx;
        dy  = sy - cy;
        tol = MW'(2) <<< F;
        snap = (dx <= tol) && (dx >= -tol) && (dy <= tol) && (dy >= -tol);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dcnt_reg  <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < 16; i++)
                coef_reg[i] <= '0;
        end
        else
        begin
            if (ov_reg && out_ch.ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (q_head.op == ppv_pkg::OP_LOAD)
                        begin
                            coef_reg[q_head.idx] <= q_head.v0;
                        end
                        else
                        begin
                            cnt_reg   <= '0;
                            state_reg <= ST_MAC;
                        end
                    end
                end
                ST_MAC:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'd15)
                        state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    dcnt_reg <= '0;
                    if (w_small)
                    begin
                        ov_reg    <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == ppv_pkg::DCNT_W'(ppv_pkg::NUM_W - 1))
                        state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    state_reg <= ST_MAP1;
                end
                ST_MAP1:
                begin
                    state_reg <= ST_MAP2;
                end
                ST_MAP2:
                begin
                    ov_reg    <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pt_reg[0] <= q_head.v0;
            pt_reg[1] <= q_head.v1;
            pt_reg[2] <= q_head.v2;
        end
        if (state_reg == ST_MAC)
        begin
            if (term == 2'd0)
                acc_reg <= ppv_pkg::ACC_W'(coef_rd);
            else
                acc_reg <= sum;
            if (term == 2'd3)
                p_reg[col] <= ppv_pkg::sat32(MW'(sum));
        end
        if (state_reg == ST_CHECK)
        begin
            dvs_reg <= abs_w[31:0];
            ok_reg  <= 1'b0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sd_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= '0;
                quo_reg[i] <= ppv_pkg::NUM_W'(abs_p[i]) << F;
                neg_reg[i] <= p_reg[i][31] ^ p_reg[3][31];
            end
        end
        if (state_reg == ST_DIV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= ge[i] ? (rs[i] - {1'b0, dvs_reg}) : rs[i];
                quo_reg[i] <= {quo_reg[i][ppv_pkg::NUM_W-2:0], ge[i]};
            end
        end
        if (state_reg == ST_NORM)
        begin
            for (int i = 0; i < 3; i++)
                n_reg[i] <= qc[i][ppv_pkg::NDC_W-1:0];
        end
        if (state_reg == ST_MAP1)
        begin
            mx_reg <= ax * MW'($signed({1'b0, view.width}));
            my_reg <= ay * MW'($signed({1'b0, view.height}));
        end
        if (state_reg == ST_MAP2)
        begin
            ok_reg <= 1'b1;
            sx_reg <= ppv_pkg::sat32(snap ? cx : sx);
            sy_reg <= ppv_pkg::sat32(snap ? cy : sy);
            sd_reg <= ppv_pkg::sat32(MW'(n_reg[2]));
        end
    end

endmodule

>>> rtl/ppv_checker.sv
// Port-level checker for the point projection block, bound to the top level.
module ppv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_ok,
    input logic [31:0] out_x,
    input logic [31:0] out_y,
    input logic [31:0] out_depth,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before it was taken");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ok |-> out_x == 32'd0 && out_y == 32'd0 && out_depth == 32'd0)
        else $error("failed projection carries nonzero fields");

    a_rd_upper: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:16] == 16'd0)
        else $error("register read shows bits above the 16-bit field");

    a_wr_rd: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready |=>
        (paddr != $past(paddr) || prdata == {16'd0, $past(pwdata[15:0])}))
        else $error("register read does not return the value just written");

endmodule

bind point_projection_to_viewport ppv_checker u_ppv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_ok    (out_ch.projected_ok),
    .out_x     (out_ch.screen_x),
    .out_y     (out_ch.screen_y),
    .out_depth (out_ch.screen_depth),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);
